// ===== rtl/mra_pkg.sv =====
package mra_pkg;

  // Working width of the wide datapath; products reach 128 bits.
  localparam int unsigned BW = 128;
  localparam int unsigned CW = $clog2(BW);
  localparam int unsigned WIDTH_DEF = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [1:0] ORD_EQ   = 2'd0;
  localparam logic [1:0] ORD_LESS = 2'd1;
  localparam logic [1:0] ORD_GRT  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        a_negative;
    logic [31:0] a_whole;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic        b_negative;
    logic [31:0] b_whole;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic        r_negative;
    logic [31:0] r_whole;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [1:0]  order;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== rtl/mra_addsub.sv =====
module mra_addsub #(
  parameter int unsigned W = mra_pkg::BW
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         borrow_o
);
  logic [W:0] full;

  assign full     = {1'b0, a_i} + {1'b0, b_i ^ {W{sub_i}}} + {{W{1'b0}}, sub_i};
  assign sum_o    = full[W-1:0];
  assign borrow_o = sub_i & ~full[W];
endmodule

// ===== rtl/mra_core.sv =====
module mra_core #(
  parameter int unsigned WIDTH = mra_pkg::WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mra_pkg::req_t req_i,
  output logic          ready_o,
  output logic          res_valid_o,
  output mra_pkg::res_t res_o,
  input  logic          res_take_i
);
  import mra_pkg::*;

  localparam int unsigned LIM = (WIDTH < 32) ? WIDTH : 32;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_NA, S_NB, S_P, S_Q, S_CMP, S_ADD, S_RSUB, S_NMUL, S_DAB,
    S_GCD0, S_GEVEN, S_GUEVEN, S_GLOOP, S_GSHL, S_DIV, S_DV2, S_DV3, S_FIN, S_DONE
  } state_e;

  state_e          state_q, ret_q;
  req_t            req_q;
  res_t            res_q;
  logic [63:0]     na_q, nb_q, r_q;
  logic [BW-1:0]   p_q, q_q, n_q, d_q, x_q, m_q, rem_q;
  logic [CW-1:0]   cnt_q, k_q;
  logic            sa_q, sb_q, neg_q;

  logic [BW-1:0]   add_a, add_b, add_sum, div_t;
  logic            add_sub, add_borrow, sbe;

  assign div_t = {rem_q[BW-2:0], x_q[BW-1]};
  assign sbe   = (sb_q ^ (req_q.opcode == OP_SUB)) & (nb_q != 64'd0);

  // One adder serves every phase; the state picks its operands.
  always_comb begin
    add_a   = x_q;
    add_b   = m_q;
    add_sub = 1'b0;
    unique case (state_q)
      S_CMP: begin
        add_a   = p_q;
        add_b   = q_q;
        add_sub = 1'b1;
      end
      S_ADD: begin
        add_a = p_q;
        add_b = q_q;
      end
      S_RSUB: begin
        add_a   = q_q;
        add_b   = p_q;
        add_sub = 1'b1;
      end
      S_GLOOP: begin
        add_a   = x_q;
        add_b   = m_q;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = div_t;
        add_b   = (ret_q == S_FIN) ? d_q : m_q;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = x_q;
        add_b   = m_q;
        add_sub = 1'b0;
      end
    endcase
  end

  mra_addsub #(.W(BW)) u_addsub (
    .a_i     (add_a),
    .b_i     (add_b),
    .sub_i   (add_sub),
    .sum_o   (add_sum),
    .borrow_o(add_borrow)
  );

  // In the gcd phase m_q holds u and x_q holds v (binary gcd).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q            <= req_i;
            res_q.r_negative <= 1'b0;
            res_q.r_whole    <= '0;
            res_q.r_num      <= '0;
            res_q.r_den      <= 32'd1;
            res_q.order      <= ORD_EQ;
            if (req_i.a_den == 32'd0 || req_i.b_den == 32'd0) begin
              res_q.status <= ST_ZDEN;
              state_q      <= S_DONE;
            end else begin
              res_q.status <= ST_OK;
              x_q     <= {{(BW-32){1'b0}}, req_i.a_num};
              m_q     <= {{(BW-32){1'b0}}, req_i.a_den};
              r_q     <= {32'd0, req_i.a_whole};
              ret_q   <= S_NA;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (r_q == 64'd0) begin
            state_q <= ret_q;
          end else begin
            if (r_q[0]) x_q <= add_sum;
            m_q <= {m_q[BW-2:0], 1'b0};
            r_q <= {1'b0, r_q[63:1]};
          end
        end
        S_NA: begin
          na_q    <= x_q[63:0];
          sa_q    <= req_q.a_negative & (x_q[63:0] != 64'd0);
          x_q     <= {{(BW-32){1'b0}}, req_q.b_num};
          m_q     <= {{(BW-32){1'b0}}, req_q.b_den};
          r_q     <= {32'd0, req_q.b_whole};
          ret_q   <= S_NB;
          state_q <= S_MUL;
        end
        S_NB: begin
          nb_q    <= x_q[63:0];
          sb_q    <= req_q.b_negative & (x_q[63:0] != 64'd0);
          x_q     <= '0;
          m_q     <= {{(BW-64){1'b0}}, na_q};
          r_q     <= {32'd0, req_q.b_den};
          ret_q   <= S_P;
          state_q <= S_MUL;
        end
        S_P: begin
          p_q     <= x_q;
          x_q     <= '0;
          m_q     <= {{(BW-64){1'b0}}, nb_q};
          r_q     <= {32'd0, req_q.a_den};
          ret_q   <= S_Q;
          state_q <= S_MUL;
        end
        S_Q: begin
          q_q     <= x_q;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (sa_q != sb_q) begin
            res_q.order <= sa_q ? ORD_LESS : ORD_GRT;
          end else if (p_q == q_q) begin
            res_q.order <= ORD_EQ;
          end else begin
            res_q.order <= (add_borrow ^ sa_q) ? ORD_LESS : ORD_GRT;
          end
          unique case (req_q.opcode) inside
            OP_ADD, OP_SUB: begin
              if (sa_q == sbe) begin
                neg_q   <= sa_q;
                state_q <= S_ADD;
              end else if (!add_borrow) begin
                n_q     <= add_sum;
                neg_q   <= sa_q;
                state_q <= S_DAB;
              end else begin
                neg_q   <= sbe;
                state_q <= S_RSUB;
              end
            end
            OP_MUL: begin
              neg_q   <= sa_q ^ sb_q;
              x_q     <= '0;
              m_q     <= {{(BW-64){1'b0}}, na_q};
              r_q     <= nb_q;
              ret_q   <= S_NMUL;
              state_q <= S_MUL;
            end
            OP_DIV: begin
              if (nb_q == 64'd0) begin
                res_q.status <= ST_ZDEN;
                state_q      <= S_DONE;
              end else begin
                neg_q   <= sa_q ^ sb_q;
                n_q     <= p_q;
                x_q     <= '0;
                m_q     <= {{(BW-32){1'b0}}, req_q.a_den};
                r_q     <= nb_q;
                ret_q   <= S_GCD0;
                state_q <= S_MUL;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_ADD: begin
          n_q     <= add_sum;
          state_q <= S_DAB;
        end
        S_RSUB: begin
          n_q     <= add_sum;
          state_q <= S_DAB;
        end
        S_NMUL: begin
          n_q     <= x_q;
          state_q <= S_DAB;
        end
        S_DAB: begin
          x_q     <= '0;
          m_q     <= {{(BW-32){1'b0}}, req_q.a_den};
          r_q     <= {32'd0, req_q.b_den};
          ret_q   <= S_GCD0;
          state_q <= S_MUL;
        end
        S_GCD0: begin
          d_q <= x_q;
          if (n_q == '0) begin
            state_q <= S_DONE;
          end else begin
            m_q     <= n_q;
            k_q     <= '0;
            state_q <= S_GEVEN;
          end
        end
        S_GEVEN: begin
          if (!m_q[0] && !x_q[0]) begin
            m_q <= {1'b0, m_q[BW-1:1]};
            x_q <= {1'b0, x_q[BW-1:1]};
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= S_GUEVEN;
          end
        end
        S_GUEVEN: begin
          if (!m_q[0]) m_q <= {1'b0, m_q[BW-1:1]};
          else state_q <= S_GLOOP;
        end
        S_GLOOP: begin
          if (x_q == '0) begin
            state_q <= S_GSHL;
          end else if (!x_q[0]) begin
            x_q <= {1'b0, x_q[BW-1:1]};
          end else if (add_borrow) begin
            m_q <= x_q;
            x_q <= m_q;
          end else begin
            x_q <= add_sum;
          end
        end
        S_GSHL: begin
          if (k_q == '0) begin
            x_q     <= n_q;
            rem_q   <= '0;
            cnt_q   <= CW'(BW - 1);
            ret_q   <= S_DV2;
            state_q <= S_DIV;
          end else begin
            m_q <= {m_q[BW-2:0], 1'b0};
            k_q <= k_q - 1'b1;
          end
        end
        S_DIV: begin
          if (!add_borrow) begin
            rem_q <= add_sum;
            x_q   <= {x_q[BW-2:0], 1'b1};
          end else begin
            rem_q <= div_t;
            x_q   <= {x_q[BW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ret_q;
        end
        S_DV2: begin
          n_q     <= x_q;
          x_q     <= d_q;
          rem_q   <= '0;
          cnt_q   <= CW'(BW - 1);
          ret_q   <= S_DV3;
          state_q <= S_DIV;
        end
        S_DV3: begin
          d_q     <= x_q;
          x_q     <= n_q;
          rem_q   <= '0;
          cnt_q   <= CW'(BW - 1);
          ret_q   <= S_FIN;
          state_q <= S_DIV;
        end
        S_FIN: begin
          if ((x_q >> LIM) != '0 || (d_q >> LIM) != '0) begin
            res_q.status <= ST_OVF;
          end else begin
            res_q.r_negative <= neg_q;
            res_q.r_whole    <= x_q[31:0];
            res_q.r_num      <= rem_q[31:0];
            res_q.r_den      <= d_q[31:0];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_take_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
endmodule

// ===== rtl/mixed_rational_alu.sv =====
// Exact arithmetic unit for signed mixed fractions.
// Input channel s_axis: opcode in tuser, both operands in tdata. Output
// channel m_axis: the normalized result with order and status in tdata.
// An item is moved when tvalid and tready are both high at a clock edge.
// The unit works on one item at a time; s_axis_tready is low while it runs.
// Latency is data dependent. Add, subtract, multiply and divide run five or
// six shift-add multiplies, a binary gcd and three restoring divides, all
// sharing one 128-bit adder.
// The result sits in an output register; the next item may be accepted and
// computed while it waits, and the unit holds its finished result until
// that register is free. A stalled receiver therefore only stalls the unit
// after one further item. Reset empties the output register and returns the
// sequencer to idle.
module mixed_rational_alu #(
  parameter int unsigned WIDTH = mra_pkg::WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_negative, a_whole, a_num, a_den, b_negative, b_whole, b_num, b_den
  input  logic [199:0] s_axis_tdata,
  // opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_negative, r_whole, r_num, r_den, order, status
  output logic [103:0] m_axis_tdata
);
  import mra_pkg::*;

  req_t req;
  res_t core_res, out_q;
  logic core_ready, core_valid, take, out_valid_q;

  assign req.opcode     = s_axis_tuser;
  assign req.a_negative = s_axis_tdata[0];
  assign req.a_whole    = s_axis_tdata[32:1];
  assign req.a_num      = s_axis_tdata[64:33];
  assign req.a_den      = s_axis_tdata[96:65];
  assign req.b_negative = s_axis_tdata[97];
  assign req.b_whole    = s_axis_tdata[129:98];
  assign req.b_num      = s_axis_tdata[161:130];
  assign req.b_den      = s_axis_tdata[193:162];

  assign s_axis_tready = core_ready;
  assign take          = core_valid & (~out_valid_q | m_axis_tready);

  mra_core #(.WIDTH(WIDTH)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid & core_ready),
    .req_i      (req),
    .ready_o    (core_ready),
    .res_valid_o(core_valid),
    .res_o      (core_res),
    .res_take_i (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (take) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= core_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.status, out_q.order, out_q.r_den, out_q.r_num,
                          out_q.r_whole, out_q.r_negative};
endmodule

// ===== verif/mixed_rational_alu_tb.sv =====
`timescale 1ns / 1ps

module mixed_rational_alu_tb;
  import mra_pkg::*;

  localparam logic [2:0] OP_CMP = 3'd4;
  localparam int unsigned LIM = 32;
  localparam int N_RANDOM = 1030;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  req_t pending_items[$];
  res_t expected_results[$];
  req_t cur_item;
  int   n_accepted;
  int   n_errors;
  int   holdoff_cycles;

  mixed_rational_alu DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Exact result of one item, worked out on 128-bit integers.
  function automatic res_t rational_result(req_t it);
    res_t r;
    logic [127:0] na, nb, p, q, n, d, g, x, y, t, wh, fr;
    logic sa, sb, sbe, neg;
    r = '0;
    r.r_den = 32'd1;
    r.status = ST_OK;
    if (it.a_den == 0 || it.b_den == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    na = 128'(it.a_whole) * 128'(it.a_den) + 128'(it.a_num);
    nb = 128'(it.b_whole) * 128'(it.b_den) + 128'(it.b_num);
    sa = it.a_negative && na != 0;
    sb = it.b_negative && nb != 0;
    p = na * 128'(it.b_den);
    q = nb * 128'(it.a_den);
    if (sa != sb) r.order = sa ? ORD_LESS : ORD_GRT;
    else if (p == q) r.order = ORD_EQ;
    else r.order = ((p < q) != sa) ? ORD_LESS : ORD_GRT;
    d = 128'(it.a_den) * 128'(it.b_den);
    case (it.opcode)
      OP_ADD, OP_SUB: begin
        sbe = (sb != (it.opcode == OP_SUB)) && nb != 0;
        if (sa == sbe) begin
          n = p + q; neg = sa;
        end else if (p >= q) begin
          n = p - q; neg = sa;
        end else begin
          n = q - p; neg = sbe;
        end
      end
      OP_MUL: begin
        n = na * nb; neg = sa != sb;
      end
      OP_DIV: begin
        if (nb == 0) begin
          r.status = ST_ZDEN;
          return r;
        end
        n = p; d = 128'(it.a_den) * nb; neg = sa != sb;
      end
      default: return r;
    endcase
    if (n == 0) return r;
    x = n; y = d;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    g = x;
    n = n / g; d = d / g;
    wh = n / d; fr = n % d;
    if ((wh >> LIM) != 0 || (d >> LIM) != 0) begin
      r.status = ST_OVF;
      return r;
    end
    r.r_negative = neg;
    r.r_whole = wh[31:0];
    r.r_num = fr[31:0];
    r.r_den = d[31:0];
    return r;
  endfunction

  // Mostly small parts so that results fit; now and then the full range.
  function automatic logic [31:0] rand_part(bit allow_zero);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 12);
      4, 5, 6:    v = $urandom_range(0, 300);
      7:          v = $urandom_range(0, 65535);
      8:          v = $urandom;
      default:    v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
    if (!allow_zero && v == 0) v = 32'd1;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Sender: 15 percent idle, except while items 500 to 699 are accepted, when it never idles.
  // The item taken at this edge is predicted before the next one is fetched.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(rational_result(cur_item));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 &&
            ((n_accepted >= 500 && n_accepted < 700) || $urandom_range(0, 99) >= 15)) begin
          cur_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_item.opcode;
          s_axis_tdata <= {6'd0, cur_item.b_den, cur_item.b_num, cur_item.b_whole,
                           cur_item.b_negative, cur_item.a_den, cur_item.a_num,
                           cur_item.a_whole, cur_item.a_negative};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off: once, the output stays blocked for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) holdoff_cycles <= -1;
    else if (holdoff_cycles < 0 && n_accepted == 200) holdoff_cycles <= 6000;
    else if (holdoff_cycles > 0) holdoff_cycles <= holdoff_cycles - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= holdoff_cycles <= 0 &&
                       ((n_accepted >= 500 && n_accepted < 700) ||
                        $urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[0] !== want.r_negative)
          report_mismatch("r_negative", 32'(m_axis_tdata[0]), 32'(want.r_negative));
        if (m_axis_tdata[32:1] !== want.r_whole)
          report_mismatch("r_whole", m_axis_tdata[32:1], want.r_whole);
        if (m_axis_tdata[64:33] !== want.r_num)
          report_mismatch("r_num", m_axis_tdata[64:33], want.r_num);
        if (m_axis_tdata[96:65] !== want.r_den)
          report_mismatch("r_den", m_axis_tdata[96:65], want.r_den);
        if (m_axis_tdata[98:97] !== want.order)
          report_mismatch("order", 32'(m_axis_tdata[98:97]), 32'(want.order));
        if (m_axis_tdata[100:99] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata[100:99]), 32'(want.status));
      end
    end
  end

  initial begin
    req_t it;
    n_accepted = 0;
    n_errors = 0;
    rst_ni = 1'b0;
    // Directed items: extremes, every opcode, the special cases.
    it = '{OP_ADD, 1'b0, 32'd1, 32'd1, 32'd2, 1'b0, 32'd0, 32'd1, 32'd3};
    pending_items.push_back(it);
    it = '{OP_SUB, 1'b0, 32'd1, 32'd1, 32'd3, 1'b0, 32'd2, 32'd1, 32'd2};
    pending_items.push_back(it);
    it = '{OP_SUB, 1'b1, 32'd3, 32'd5, 32'd4, 1'b1, 32'd3, 32'd5, 32'd4};
    pending_items.push_back(it);
    it = '{OP_MUL, 1'b1, 32'd2, 32'd2, 32'd3, 1'b0, 32'd1, 32'd7, 32'd5};
    pending_items.push_back(it);
    it = '{OP_DIV, 1'b0, 32'd5, 32'd0, 32'd1, 1'b1, 32'd0, 32'd2, 32'd3};
    pending_items.push_back(it);
    it = '{OP_CMP, 1'b1, 32'd0, 32'd1, 32'd2, 1'b1, 32'd0, 32'd1, 32'd3};
    pending_items.push_back(it);
    // Negative zero against positive zero.
    it = '{OP_ADD, 1'b1, 32'd0, 32'd0, 32'd5, 1'b0, 32'd0, 32'd0, 32'd7};
    pending_items.push_back(it);
    it = '{OP_SUB, 1'b1, 32'd0, 32'd0, 32'd5, 1'b1, 32'd0, 32'd0, 32'd9};
    pending_items.push_back(it);
    // Zero denominators on either side.
    it = '{OP_ADD, 1'b0, 32'd1, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1, 32'd2};
    pending_items.push_back(it);
    it = '{OP_CMP, 1'b1, 32'd4, 32'd1, 32'd2, 1'b0, 32'd1, 32'd1, 32'd0};
    pending_items.push_back(it);
    // Divide by zero, with a negative-zero divisor too.
    it = '{OP_DIV, 1'b0, 32'd3, 32'd1, 32'd2, 1'b0, 32'd0, 32'd0, 32'd4};
    pending_items.push_back(it);
    it = '{OP_DIV, 1'b1, 32'd3, 32'd1, 32'd2, 1'b1, 32'd0, 32'd0, 32'd1};
    pending_items.push_back(it);
    // Overflow of the whole part and of the denominator.
    it = '{OP_MUL, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd1};
    pending_items.push_back(it);
    it = '{OP_ADD, 1'b0, 32'd0, 32'd1, 32'hFFFF_FFFB, 1'b0, 32'd0, 32'd1, 32'hFFFF_FFFD};
    pending_items.push_back(it);
    it = '{OP_DIV, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd1,
           32'hFFFF_FFFF};
    pending_items.push_back(it);
    // Improper fractions and all-ones fields.
    it = '{OP_ADD, 1'b1, 32'd2, 32'd17, 32'd4, 1'b0, 32'd0, 32'd9, 32'd3};
    pending_items.push_back(it);
    it = '{OP_SUB, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    pending_items.push_back(it);
    it = '{OP_CMP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 32'd1};
    pending_items.push_back(it);
    // Unassigned opcodes behave as compare.
    it = '{3'd5, 1'b0, 32'd1, 32'd0, 32'd1, 1'b0, 32'd2, 32'd0, 32'd1};
    pending_items.push_back(it);
    it = '{3'd6, 1'b1, 32'd1, 32'd0, 32'd1, 1'b0, 32'd2, 32'd0, 32'd1};
    pending_items.push_back(it);
    it = '{3'd7, 1'b0, 32'd2, 32'd3, 32'd6, 1'b0, 32'd2, 32'd1, 32'd2};
    pending_items.push_back(it);
    for (int i = 0; i < N_RANDOM; i++) begin
      it.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
      it.a_negative = 1'($urandom_range(0, 1));
      it.b_negative = 1'($urandom_range(0, 1));
      it.a_whole = rand_part(1'b1);
      it.a_num = rand_part(1'b1);
      it.a_den = rand_part($urandom_range(0, 19) == 0);
      it.b_whole = rand_part(1'b1);
      it.b_num = rand_part(1'b1);
      it.b_den = rand_part($urandom_range(0, 19) == 0);
      pending_items.push_back(it);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (n_errors == 0) $display("mixed_rational_alu_tb: done, clean");
    else $display("mixed_rational_alu_tb: done, errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("mixed_rational_alu_tb: done, errors");
    $finish;
  end

endmodule
